// ===== design/crsp_pkg.sv =====
package crsp_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_SLOTS = 4;
  localparam int COORD_BITS  = 16;

  localparam int IN_W   = 16;
  localparam int FLD_W  = 16;
  localparam int CFG_W  = 64;
  localparam int STEP_W = 22;

  localparam logic [IN_W-1:0] CMASK =
    (COORD_BITS >= IN_W) ? {IN_W{1'b1}} : IN_W'((1 << COORD_BITS) - 1);

  // radicand ((dx^2+dy^2) << 4), root and arithmetic widths
  localparam int SQ_W  = 2 * FLD_W + 1 + 4;
  localparam int RT_W  = (SQ_W + 1) / 2;
  localparam int RAD_W = 2 * RT_W;
  localparam int DL_W  = RT_W + 1;
  localparam int PR_W  = DL_W + FLD_W + 1;
  localparam int Q_W   = PR_W - 13;

  localparam logic [PR_W:0]  RND_HALF = (PR_W + 1)'(8192);
  localparam logic [Q_W-1:0] SAT_POS  = Q_W'((1 << (STEP_W - 1)) - 1);
  localparam logic [Q_W-1:0] SAT_NEG  = Q_W'(1 << (STEP_W - 1));

  // pipeline stage numbers
  localparam int ST_IN  = 1;
  localparam int ST_DIF = 2;
  localparam int ST_SQR = 3;
  localparam int ST_RAD = 4;
  localparam int ST_RT0 = 5;
  localparam int ST_DEL = ST_RT0 + RT_W;
  localparam int ST_PRD = ST_DEL + 1;
  localparam int ST_MAG = ST_PRD + 1;
  localparam int NSTG   = ST_MAG + 1;

  typedef enum logic [2:0] {
    CFG_WS_W    = 3'd0,
    CFG_WS_H    = 3'd1,
    CFG_ANC_X   = 3'd2,
    CFG_ANC_Y   = 3'd3,
    CFG_SPM     = 3'd4,
    CFG_MIN_STP = 3'd5,
    CFG_DIR     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [NSTG:1] en;
  } crsp_ctl_t;

endpackage

// ===== design/crsp_isqrt.sv =====
module crsp_isqrt (
  input  logic                          clk,
  input  logic [crsp_pkg::RT_W-1:0]     en,
  input  logic [crsp_pkg::RAD_W-1:0]    rad_in,
  output logic [crsp_pkg::RT_W-1:0]     root
);

  localparam int RW = crsp_pkg::RT_W;
  localparam int DW = crsp_pkg::RAD_W;
  localparam int MW = RW + 2;

  logic [DW-1:0] rad_r  [RW];
  logic [MW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];

  // one root bit per stage, restoring
  for (genvar j = 0; j < RW; j++) begin : g_stg
    logic [DW-1:0] rad_p;
    logic [MW-1:0] rem_p;
    logic [RW-1:0] root_p;
    logic [MW-1:0] shf;
    logic [MW-1:0] trial;

    if (j == 0) begin : g_first
      assign rad_p  = rad_in;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
    end

    assign shf   = {rem_p[MW-3:0], rad_p[DW-1:DW-2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rad_r[j] <= rad_p << 2;
        if (shf >= trial) begin
          rem_r[j]  <= shf - trial;
          root_r[j] <= {root_p[RW-2:0], 1'b1};
        end else begin
          rem_r[j]  <= shf;
          root_r[j] <= {root_p[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== design/crsp_lane.sv =====
module crsp_lane (
  input  logic                               clk,
  input  crsp_pkg::crsp_ctl_t                ctl,
  input  logic [crsp_pkg::IN_W-1:0]          cx,
  input  logic [crsp_pkg::IN_W-1:0]          cy,
  input  logic [crsp_pkg::IN_W-1:0]          tx,
  input  logic [crsp_pkg::IN_W-1:0]          ty,
  input  logic [crsp_pkg::FLD_W-1:0]         ax,
  input  logic [crsp_pkg::FLD_W-1:0]         ay,
  input  logic [crsp_pkg::FLD_W-1:0]         spm,
  input  logic [7:0]                         min_steps,
  input  logic                               dir,
  output logic signed [crsp_pkg::STEP_W-1:0] steps
);

  localparam int FW = crsp_pkg::FLD_W;
  localparam int SW = crsp_pkg::SQ_W;
  localparam int PW = crsp_pkg::PR_W;
  localparam int QW = crsp_pkg::Q_W;

  logic [FW-1:0]     dcx_r, dcy_r, dtx_r, dty_r;
  logic [2*FW-1:0]   scx_r, scy_r, stx_r, sty_r;
  logic [SW-1:0]     radc_r, radt_r;
  logic [crsp_pkg::RT_W-1:0] rtc, rtt;
  logic signed [crsp_pkg::DL_W-1:0] del_r;
  logic signed [PW-1:0] prd_r;
  logic [PW-1:0]     mag_r;
  logic              sgn_r;
  logic signed [crsp_pkg::STEP_W-1:0] steps_r;

  logic [PW:0]   rnd;
  logic [QW-1:0] q;
  logic [QW-1:0] qm;

  function automatic logic [FW-1:0] adiff(logic [FW-1:0] a, logic [FW-1:0] b);
    adiff = (a > b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.en[crsp_pkg::ST_DIF]) begin
      dcx_r <= adiff(FW'(cx), ax);
      dcy_r <= adiff(FW'(cy), ay);
      dtx_r <= adiff(FW'(tx), ax);
      dty_r <= adiff(FW'(ty), ay);
    end
    if (ctl.en[crsp_pkg::ST_SQR]) begin
      scx_r <= dcx_r * dcx_r;
      scy_r <= dcy_r * dcy_r;
      stx_r <= dtx_r * dtx_r;
      sty_r <= dty_r * dty_r;
    end
    if (ctl.en[crsp_pkg::ST_RAD]) begin
      radc_r <= {({1'b0, scx_r} + {1'b0, scy_r}), 4'b0000};
      radt_r <= {({1'b0, stx_r} + {1'b0, sty_r}), 4'b0000};
    end
  end

  crsp_isqrt u_sqrt_cur (
    .clk    (clk),
    .en     (ctl.en[crsp_pkg::ST_RT0 +: crsp_pkg::RT_W]),
    .rad_in (crsp_pkg::RAD_W'(radc_r)),
    .root   (rtc)
  );

  crsp_isqrt u_sqrt_tgt (
    .clk    (clk),
    .en     (ctl.en[crsp_pkg::ST_RT0 +: crsp_pkg::RT_W]),
    .rad_in (crsp_pkg::RAD_W'(radt_r)),
    .root   (rtt)
  );

  // round half away from zero, then threshold, sign and clamp
  assign rnd = {1'b0, mag_r} + crsp_pkg::RND_HALF;
  assign q   = rnd[PW:14];
  assign qm  = (q < QW'(min_steps)) ? '0 : q;

  always_ff @(posedge clk) begin
    if (ctl.en[crsp_pkg::ST_DEL]) begin
      del_r <= $signed({1'b0, rtt}) - $signed({1'b0, rtc});
    end
    if (ctl.en[crsp_pkg::ST_PRD]) begin
      prd_r <= del_r * $signed({1'b0, spm});
    end
    if (ctl.en[crsp_pkg::ST_MAG]) begin
      mag_r <= prd_r[PW-1] ? PW'(-prd_r) : PW'(prd_r);
      sgn_r <= prd_r[PW-1] ^ dir;
    end
    if (ctl.en[crsp_pkg::NSTG]) begin
      if (sgn_r) begin
        steps_r <= (qm > crsp_pkg::SAT_NEG) ? {1'b1, {(crsp_pkg::STEP_W-1){1'b0}}}
                                           : crsp_pkg::STEP_W'(-qm);
      end else begin
        steps_r <= (qm > crsp_pkg::SAT_POS) ? {1'b0, {(crsp_pkg::STEP_W-1){1'b1}}}
                                           : crsp_pkg::STEP_W'(qm);
      end
    end
  end

  assign steps = steps_r;

endmodule

// ===== design/cable_robot_step_planner_unit.sv =====
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | current_x/y, target_x/y (16b each)
// out_    | output    | out_valid / out_stall| in_workspace, steps_motor_0..3 (22b s)
// cfg_    | input     | cfg_we               | cfg_index (3b), cfg_wdata (64b)
//
// Stages: input reg, diff, square, radicand, 19 root stages, delta, multiply,
// magnitude, output reg; one item per cycle sustained while out_stall is low.
// The square roots are the 19 one-bit stages of a restoring root pipeline.
// Each stage holds only while it is full and the next one holds, so bubbles
// collapse and input is taken while a result waits on out_stall if any stage is empty.
// rst_n (sync, low) clears valid bits and loads the register reset values.
module cable_robot_step_planner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_current_x,
  input  logic [15:0] in_current_y,
  input  logic [15:0] in_target_x,
  input  logic [15:0] in_target_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_in_workspace,
  output logic signed [21:0] out_steps_motor_0,
  output logic signed [21:0] out_steps_motor_1,
  output logic signed [21:0] out_steps_motor_2,
  output logic signed [21:0] out_steps_motor_3,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int N  = crsp_pkg::NSTG;
  localparam int IW = crsp_pkg::IN_W;
  localparam int FW = crsp_pkg::FLD_W;
  localparam int SW = crsp_pkg::STEP_W;

  // configuration registers
  logic [15:0] ws_w_r, ws_h_r;
  logic [63:0] anc_x_r, anc_y_r, spm_r;
  logic [7:0]  min_r;
  logic [3:0]  dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_w_r  <= 16'd16000;
      ws_h_r  <= 16'd16000;
      anc_x_r <= '0;
      anc_y_r <= '0;
      spm_r   <= '0;
      min_r   <= 8'd1;
      dir_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crsp_pkg::CFG_WS_W:    ws_w_r  <= cfg_wdata[15:0];
        crsp_pkg::CFG_WS_H:    ws_h_r  <= cfg_wdata[15:0];
        crsp_pkg::CFG_ANC_X:   anc_x_r <= cfg_wdata;
        crsp_pkg::CFG_ANC_Y:   anc_y_r <= cfg_wdata;
        crsp_pkg::CFG_SPM:     spm_r   <= cfg_wdata;
        crsp_pkg::CFG_MIN_STP: min_r   <= cfg_wdata[7:0];
        crsp_pkg::CFG_DIR:     dir_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // stage valids, workspace flag and per-stage load enables
  logic [N:1] v_r;
  logic [N:1] ins_r;
  crsp_pkg::crsp_ctl_t ctl;

  always_comb begin
    ctl.en[N] = !v_r[N] || !out_stall;
    for (int k = N - 1; k >= 1; k--) begin
      ctl.en[k] = !v_r[k] || ctl.en[k+1];
    end
  end

  assign in_stall = !ctl.en[1];

  logic [IW-1:0] cx, cy, tx, ty;
  assign cx = in_current_x & crsp_pkg::CMASK;
  assign cy = in_current_y & crsp_pkg::CMASK;
  assign tx = in_target_x  & crsp_pkg::CMASK;
  assign ty = in_target_y  & crsp_pkg::CMASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ctl.en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= N; k++) begin
        if (ctl.en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      ins_r[1] <= (tx <= ws_w_r) && (ty <= ws_h_r);
    end
    for (int k = 2; k <= N; k++) begin
      if (ctl.en[k]) begin
        ins_r[k] <= ins_r[k-1];
      end
    end
  end

  // stage 1 coordinate registers
  logic [IW-1:0] cx_r, cy_r, tx_r, ty_r;
  always_ff @(posedge clk) begin
    if (ctl.en[crsp_pkg::ST_IN]) begin
      cx_r <= cx;
      cy_r <= cy;
      tx_r <= tx;
      ty_r <= ty;
    end
  end

  // one lane per motor; unused slots read zero
  logic signed [SW-1:0] lane_steps [crsp_pkg::MOTOR_SLOTS];

  for (genvar m = 0; m < crsp_pkg::MOTOR_SLOTS; m++) begin : g_mot
    if (m < crsp_pkg::MOTOR_COUNT) begin : g_lane
      crsp_lane u_lane (
        .clk       (clk),
        .ctl       (ctl),
        .cx        (cx_r),
        .cy        (cy_r),
        .tx        (tx_r),
        .ty        (ty_r),
        .ax        (anc_x_r[m*FW +: FW]),
        .ay        (anc_y_r[m*FW +: FW]),
        .spm       (spm_r[m*FW +: FW]),
        .min_steps (min_r),
        .dir       (dir_r[m]),
        .steps     (lane_steps[m])
      );
    end else begin : g_off
      assign lane_steps[m] = '0;
    end
  end

  assign out_valid        = v_r[N];
  assign out_in_workspace = ins_r[N];
  assign out_steps_motor_0 = ins_r[N] ? lane_steps[0] : '0;
  assign out_steps_motor_1 = ins_r[N] ? lane_steps[1] : '0;
  assign out_steps_motor_2 = ins_r[N] ? lane_steps[2] : '0;
  assign out_steps_motor_3 = ins_r[N] ? lane_steps[3] : '0;

endmodule

// ===== test/cable_robot_step_planner_unit_tb.sv =====
module cable_robot_step_planner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index outside the register map; writes to it must change nothing
  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;   // extra wait once nothing is queued or expected

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] tx;
    logic [15:0] ty;
  } seg_t;

  typedef struct packed {
    logic ok;
    logic [3:0][21:0] st;
  } plan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_current_x = '0;
  logic [15:0] in_current_y = '0;
  logic [15:0] in_target_x = '0;
  logic [15:0] in_target_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_in_workspace;
  logic signed [21:0] out_steps_motor_0;
  logic signed [21:0] out_steps_motor_1;
  logic signed [21:0] out_steps_motor_2;
  logic signed [21:0] out_steps_motor_3;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  cable_robot_step_planner_unit u_top (.*);

  // shadow copy of the block's registers
  logic [15:0] ws_w, ws_h;
  logic [63:0] anc_x, anc_y, spm_all;
  logic [7:0]  min_steps;
  logic [3:0]  dir_mask;

  seg_t  seg_q[$];     // items waiting to be driven
  plan_t plan_q[$];    // expected plans, oldest first
  int    errors = 0;
  int    n_items = 0;
  int    n_plans = 0;
  int    n_inside = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // cable length in 1/64 mm
  function automatic longint cable_len(logic [15:0] x, y, ax, ay);
    logic [63:0] dx, dy;
    dx = (x > ax) ? 64'(x - ax) : 64'(ax - x);
    dy = (y > ay) ? 64'(y - ay) : 64'(ay - y);
    return longint'(isqrt((dx * dx + dy * dy) << 4));
  endfunction

  function automatic plan_t plan_segment(seg_t s);
    plan_t p;
    logic [15:0] cx, cy, tx, ty, ax, ay;
    longint spm, delta, prod, steps;
    logic [63:0] mag, q;
    logic neg;
    p = '0;
    cx = s.cx & crsp_pkg::CMASK;
    cy = s.cy & crsp_pkg::CMASK;
    tx = s.tx & crsp_pkg::CMASK;
    ty = s.ty & crsp_pkg::CMASK;
    if (tx > ws_w || ty > ws_h) return p;
    p.ok = 1'b1;
    for (int m = 0; m < crsp_pkg::MOTOR_COUNT && m < 4; m++) begin
      ax = anc_x[m*16 +: 16];
      ay = anc_y[m*16 +: 16];
      spm = longint'({48'd0, spm_all[m*16 +: 16]});
      delta = cable_len(tx, ty, ax, ay) - cable_len(cx, cy, ax, ay);
      prod = delta * spm;
      neg = prod < 0;
      mag = neg ? 64'(-prod) : 64'(prod);
      q = (mag + 64'd8192) >> 14;
      if (q < {56'd0, min_steps}) q = 0;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      steps = neg ? -longint'(q) : longint'(q);
      if (dir_mask[m]) steps = -steps;
      if (steps > 2097151) steps = 2097151;
      if (steps < -2097152) steps = -2097152;
      p.st[m] = steps[21:0];
    end
    return p;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on plan %0d: %s got %0h want %0h", n_plans, what, got, want);
  endtask

  // driver: hold a stalled item, otherwise maybe load the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        plan_q.push_back(plan_segment({in_current_x, in_current_y, in_target_x, in_target_y}));
        n_items++;
      end
      if (seg_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        seg_t s;
        s = seg_q.pop_front();
        in_current_x <= s.cx;
        in_current_y <= s.cy;
        in_target_x  <= s.tx;
        in_target_y  <= s.ty;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted plan with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        logic [21:0] got [4];
        got[0] = out_steps_motor_0;
        got[1] = out_steps_motor_1;
        got[2] = out_steps_motor_2;
        got[3] = out_steps_motor_3;
        if (plan_q.size() == 0) begin
          report("unexpected plan", out_in_workspace, 0);
        end else begin
          plan_t w;
          w = plan_q.pop_front();
          if (out_in_workspace !== w.ok) report("in_workspace", out_in_workspace, w.ok);
          for (int m = 0; m < 4; m++)
            if (got[m] !== w.st[m]) report($sformatf("steps_motor_%0d", m), got[m], w.st[m]);
          if (w.ok) n_inside++;
        end
        n_plans++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      crsp_pkg::CFG_WS_W:    ws_w = d[15:0];
      crsp_pkg::CFG_WS_H:    ws_h = d[15:0];
      crsp_pkg::CFG_ANC_X:   anc_x = d;
      crsp_pkg::CFG_ANC_Y:   anc_y = d;
      crsp_pkg::CFG_SPM:     spm_all = d;
      crsp_pkg::CFG_MIN_STP: min_steps = d[7:0];
      crsp_pkg::CFG_DIR:     dir_mask = d[3:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until nothing is queued, in flight or expected
  task automatic drain();
    @(negedge clk);
    while (seg_q.size() != 0 || in_valid || plan_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_seg(logic [15:0] cx, cy, tx, ty);
    seg_q.push_back({cx, cy, tx, ty});
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(255));
      2: return 16'(65535 - $urandom_range(255));
      default: return 16'($urandom_range(20000));
    endcase
  endfunction

  // mostly targets inside the workspace, some anywhere
  task automatic add_random(int n);
    logic [15:0] tx, ty;
    repeat (n) begin
      if ($urandom_range(9) < 8) begin
        tx = 16'($urandom_range(ws_w));
        ty = 16'($urandom_range(ws_h));
        if ($urandom_range(9) == 0) tx = ws_w;
        if ($urandom_range(9) == 0) ty = ws_h;
      end else begin
        tx = rnd16();
        ty = rnd16();
      end
      if ($urandom_range(9) == 0) add_seg(tx, ty, tx, ty);
      else add_seg(rnd16(), rnd16(), tx, ty);
    end
  endtask

  initial begin
    ws_w = 16000;
    ws_h = 16000;
    anc_x = '0;
    anc_y = '0;
    spm_all = '0;
    min_steps = 8'd1;
    dir_mask = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      // idling pattern rotates: none, sender, receiver, both
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      case (ph)
        0: begin
          // reset values: zero factors, so only the workspace flag moves
          add_seg(0, 0, 16000, 16000);
          add_seg(0, 0, 16001, 0);
          add_seg(65535, 65535, 0, 16001);
          add_random(60);
        end
        1: begin
          cfg_write(crsp_pkg::CFG_WS_W, 16000);
          cfg_write(crsp_pkg::CFG_WS_H, 12000);
          cfg_write(crsp_pkg::CFG_ANC_X, {16'd0, 16'd16000, 16'd16000, 16'd0});
          cfg_write(crsp_pkg::CFG_ANC_Y, {16'd12000, 16'd12000, 16'd0, 16'd0});
          cfg_write(crsp_pkg::CFG_SPM, {16'h0100, 16'h1280, 16'h5000, 16'h0C80});
          cfg_write(crsp_pkg::CFG_MIN_STP, 1);
          cfg_write(crsp_pkg::CFG_DIR, 4'b1010);
          cfg_write(CFG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
          cfg_done();
          add_seg(0, 0, 16000, 12000);      // corner to corner
          add_seg(16000, 12000, 0, 0);
          add_seg(100, 100, 16000, 12000);  // bounds are inclusive
          add_seg(100, 100, 16001, 100);    // just past x
          add_seg(100, 100, 100, 12001);    // just past y
          add_seg(65535, 65535, 0, 0);
          add_seg(8000, 6000, 8000, 6000);  // no motion
          add_seg(8000, 6000, 8001, 6000);  // a one-unit move in x
          add_seg(0, 0, 0, 0);
          add_seg(16000, 0, 0, 12000);
          add_random(150);
        end
        2: begin
          // largest workspace, largest factors, all directions flipped
          cfg_write(crsp_pkg::CFG_WS_W, 65535);
          cfg_write(crsp_pkg::CFG_WS_H, 65535);
          cfg_write(crsp_pkg::CFG_ANC_X, {16'd0, 16'd65535, 16'd65535, 16'd0});
          cfg_write(crsp_pkg::CFG_ANC_Y, {16'd65535, 16'd65535, 16'd0, 16'd0});
          cfg_write(crsp_pkg::CFG_SPM, 64'hFFFF_FFFF_FFFF_FFFF);
          cfg_write(crsp_pkg::CFG_MIN_STP, 0);
          cfg_write(crsp_pkg::CFG_DIR, 4'hF);
          cfg_done();
          add_seg(0, 0, 65535, 65535);
          add_seg(65535, 65535, 0, 0);
          add_seg(65535, 0, 0, 65535);
          add_seg(0, 65535, 65535, 0);
          add_random(200);
        end
        3: begin
          // degenerate workspace and the largest threshold
          cfg_write(crsp_pkg::CFG_WS_W, 0);
          cfg_write(crsp_pkg::CFG_WS_H, 0);
          cfg_write(crsp_pkg::CFG_MIN_STP, 255);
          cfg_write(crsp_pkg::CFG_DIR, 4'h5);
          cfg_done();
          add_seg(65535, 65535, 0, 0);
          add_seg(0, 0, 0, 1);
          add_random(150);
        end
        default: begin
          cfg_write(crsp_pkg::CFG_WS_W, 64'($urandom_range(65535)) | 64'(16'd8000));
          cfg_write(crsp_pkg::CFG_WS_H, 64'($urandom_range(65535)) | 64'(16'd8000));
          cfg_write(crsp_pkg::CFG_ANC_X, {$urandom, $urandom});
          cfg_write(crsp_pkg::CFG_ANC_Y, {$urandom, $urandom});
          cfg_write(crsp_pkg::CFG_SPM, {$urandom, $urandom});
          cfg_write(crsp_pkg::CFG_MIN_STP, 64'($urandom_range(ph == 4 ? 255 : 8)));
          cfg_write(crsp_pkg::CFG_DIR, 64'($urandom_range(15)));
          if (ph == 5) cfg_write(CFG_NONE, {$urandom, $urandom});
          cfg_done();
          add_random(250);
        end
      endcase
      drain();
    end

    $display("%0d items in 8 register settings, %0d plans checked (%0d inside workspace)",
             n_items, n_plans, n_inside);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== cable_robot_step_planner_unit.f =====
design/crsp_pkg.sv
design/crsp_isqrt.sv
design/crsp_lane.sv
design/cable_robot_step_planner_unit.sv
test/cable_robot_step_planner_unit_tb.sv
